// ===== src/hjog_pkg.sv =====
// Shared types and constants for the handwheel jog axis controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package hjog_pkg;

	typedef logic signed [15:0] pos_t;
	typedef logic [9:0] rate_t;
	typedef logic [1:0] axis_t;

	// event kinds
	localparam logic [1:0] OP_ENCODER = 2'd0;
	localparam logic [1:0] OP_BUTTONS = 2'd1;
	localparam logic [1:0] OP_RATE    = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	// axis codes
	localparam axis_t AXIS_NONE = 2'd0;
	localparam axis_t AXIS_X    = 2'd1;
	localparam axis_t AXIS_Y    = 2'd2;
	localparam axis_t AXIS_Z    = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_X_LO  = 3'd0;
	localparam logic [2:0] REG_X_HI  = 3'd1;
	localparam logic [2:0] REG_Y_LO  = 3'd2;
	localparam logic [2:0] REG_Y_HI  = 3'd3;
	localparam logic [2:0] REG_Z_LO  = 3'd4;
	localparam logic [2:0] REG_Z_HI  = 3'd5;
	localparam logic [2:0] REG_DELAY = 3'd6;

	localparam pos_t X_LO_RST = -16'sd14750;
	localparam pos_t X_HI_RST = 16'sd14750;
	localparam pos_t Y_LO_RST = -16'sd12000;
	localparam pos_t Y_HI_RST = 16'sd12000;
	localparam pos_t Z_LO_RST = -16'sd25000;
	localparam pos_t Z_HI_RST = 16'sd0;
	localparam logic [7:0] DELAY_RST = 8'd10;

	// quadrature history codes
	localparam logic [3:0] HIST_UP   = 4'h6;
	localparam logic [3:0] HIST_DOWN = 4'hC;

	localparam logic [6:0] STEP_1   = 7'd1;
	localparam logic [6:0] STEP_10  = 7'd10;
	localparam logic [6:0] STEP_100 = 7'd100;

	localparam logic [9:0] RATE_MASK = 10'h3F8;
	localparam logic [7:0] TICK_MAX  = 8'd255;

	typedef struct packed {
		pos_t [3:0] lo;   // indexed by axis code, axis none is zero
		pos_t [3:0] hi;
		logic [7:0] delay;
	} cfg_t;

	typedef struct packed {
		logic  sent;
		axis_t axis;
		pos_t  position;
		rate_t rate;
	} result_t;

endpackage
`default_nettype wire

// ===== src/hjog_cfg.sv =====
// Configuration register file: axis limits and send delay.
// Depends on hjog_pkg.
`default_nettype none
module hjog_cfg import hjog_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data,
	output cfg_t             cfg
);

	pos_t x_lo_q, x_hi_q, y_lo_q, y_hi_q, z_lo_q, z_hi_q;
	logic [7:0] delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo_q  <= X_LO_RST;
			x_hi_q  <= X_HI_RST;
			y_lo_q  <= Y_LO_RST;
			y_hi_q  <= Y_HI_RST;
			z_lo_q  <= Z_LO_RST;
			z_hi_q  <= Z_HI_RST;
			delay_q <= DELAY_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_X_LO:  x_lo_q  <= wr_data;
				REG_X_HI:  x_hi_q  <= wr_data;
				REG_Y_LO:  y_lo_q  <= wr_data;
				REG_Y_HI:  y_hi_q  <= wr_data;
				REG_Z_LO:  z_lo_q  <= wr_data;
				REG_Z_HI:  z_hi_q  <= wr_data;
				REG_DELAY: delay_q <= wr_data[7:0];
				default: ;  // unused index, write dropped
			endcase
		end
	end

	always_comb begin
		cfg.lo    = {z_lo_q, y_lo_q, x_lo_q, 16'sd0};
		cfg.hi    = {z_hi_q, y_hi_q, x_hi_q, 16'sd0};
		cfg.delay = delay_q;
	end

endmodule
`default_nettype wire

// ===== src/hjog_core.sv =====
// Jog state and per-word update: encoder decode, clamp, button decode,
// rate capture and tick-driven send. Depends on hjog_pkg.
`default_nettype none
module hjog_core import hjog_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [1:0] operation,
	input  wire logic [1:0] encoder_bits,
	input  wire logic [5:0] buttons,
	input  wire logic [9:0] rate_sample,
	input  wire cfg_t       cfg,
	output result_t         result
);

	logic [3:0] hist_q, hist_d;
	axis_t      sel_q, sel_d;
	logic [6:0] step_q, step_d;
	logic       pend_q, pend_d;
	logic [7:0] tick_q, tick_d, tick_inc;
	pos_t [3:0] pos_q, pos_d;
	rate_t [3:0] rate_q, rate_d;

	logic signed [17:0] sum, lo18, hi18, clamped;
	logic [17:0] step18;
	logic up, down, sent;
	axis_t rep_axis;

	always_comb begin
		hist_d   = hist_q;
		sel_d    = sel_q;
		step_d   = step_q;
		pend_d   = pend_q;
		tick_d   = tick_q;
		pos_d    = pos_q;
		rate_d   = rate_q;
		sent     = 1'b0;
		rep_axis = sel_q;

		// encoder move, add then clamp against the selected axis limits
		up     = ({hist_q[1:0], encoder_bits} == HIST_UP);
		down   = ({hist_q[1:0], encoder_bits} == HIST_DOWN);
		step18 = {11'd0, step_q};
		sum    = {{2{pos_q[sel_q][15]}}, pos_q[sel_q]} +
			$signed(down ? (18'd0 - step18) : step18);
		lo18 = {{2{cfg.lo[sel_q][15]}}, cfg.lo[sel_q]};
		hi18 = {{2{cfg.hi[sel_q][15]}}, cfg.hi[sel_q]};
		clamped = sum;
		if (clamped > hi18) clamped = hi18;
		if (clamped < lo18) clamped = lo18;  // crossed limits end at lower

		tick_inc = (tick_q == TICK_MAX) ? TICK_MAX : tick_q + 8'd1;

		case (operation)
			OP_ENCODER: begin
				hist_d = {hist_q[1:0], encoder_bits};
				if (up || down) begin
					pos_d[sel_q] = clamped[15:0];
					pend_d       = 1'b1;
				end
			end
			OP_BUTTONS: begin
				if (buttons != 6'd0) begin
					sent   = pend_q && (sel_q != AXIS_NONE);
					tick_d = 8'd0;
					pend_d = 1'b0;
					if (buttons[0])      sel_d = AXIS_X;
					else if (buttons[1]) sel_d = AXIS_Y;
					else if (buttons[2]) sel_d = AXIS_Z;
					else                 sel_d = AXIS_NONE;
					if (buttons[3])      step_d = STEP_1;
					else if (buttons[4]) step_d = STEP_10;
					else if (buttons[5]) step_d = STEP_100;
					else                 step_d = 7'd0;
					rep_axis = sent ? sel_q : sel_d;
				end
			end
			OP_RATE: begin
				rate_d[sel_q] = rate_sample & RATE_MASK;
			end
			default: begin  // timer tick
				tick_d = tick_inc;
				if (tick_inc >= cfg.delay && pend_q && sel_q != AXIS_NONE) begin
					sent   = 1'b1;
					tick_d = 8'd0;
					pend_d = 1'b0;
				end
			end
		endcase

		result.sent     = sent;
		result.axis     = rep_axis;
		result.position = pos_d[rep_axis];
		result.rate     = rate_d[rep_axis];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= 4'd0;
			sel_q  <= AXIS_NONE;
			step_q <= 7'd0;
			pend_q <= 1'b0;
			tick_q <= 8'd0;
			pos_q  <= '0;
			rate_q <= '0;
		end else if (advance) begin
			hist_q <= hist_d;
			sel_q  <= sel_d;
			step_q <= step_d;
			pend_q <= pend_d;
			tick_q <= tick_d;
			pos_q  <= pos_d;
			rate_q <= rate_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/handwheel_jog_axis_controller.sv =====
// Top level of the handwheel jog axis controller: input register, core
// update, result register. Depends on hjog_pkg, hjog_cfg, hjog_core.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | operation, encoder_bits, buttons, rate_sample
//  out     | out_valid / out_ready| command_sent, axis, position, rate
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each word passes through the input register, then the state update and
// result capture in the output register. One word per cycle is sustained
// while out_ready stays high; the core updates state as a word moves
// from the input register to the output register.
// A stalled output holds the input register; in_ready drops only when both
// registers are full and out_ready is low. Reset loads the limit defaults.
`default_nettype none
module handwheel_jog_axis_controller import hjog_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [1:0]  encoder_bits,
	input  wire logic [5:0]  buttons,
	input  wire logic [9:0]  rate_sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             command_sent,
	output logic [1:0]       axis,
	output logic signed [15:0] position,
	output logic [9:0]       rate,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic       valid_s1;
	logic [1:0] op_s1, enc_s1;
	logic [5:0] btn_s1;
	logic [9:0] smp_s1;
	logic       valid_s2;
	result_t    res_s2, res;
	cfg_t       cfg;
	logic       advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= operation;
			enc_s1 <= encoder_bits;
			btn_s1 <= buttons;
			smp_s1 <= rate_sample;
		end
		if (advance) res_s2 <= res;
	end

	hjog_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	hjog_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.operation    (op_s1),
		.encoder_bits (enc_s1),
		.buttons      (btn_s1),
		.rate_sample  (smp_s1),
		.cfg          (cfg),
		.result       (res)
	);

	assign out_valid    = valid_s2;
	assign command_sent = res_s2.sent;
	assign axis         = res_s2.axis;
	assign position     = res_s2.position;
	assign rate         = res_s2.rate;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for handwheel_jog_axis_controller: directed table, then random
// phases under varied limits, send delays and handshake pressure. Depends on hjog_pkg.
`default_nettype none
module tb_top;
	import hjog_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 244;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] enc;
		logic [5:0] btn;
		logic [9:0] smp;
	} jog_word_t;

	typedef struct packed {
		jog_word_t w;
		logic      typed;
		result_t   want;
	} dir_row_t;

	// runs with send delay 0 and the reset limits
	localparam dir_row_t DIRECTED [27] = '{
		'{'{OP_TICK,    2'd0, 6'd0,       10'd0},    1'b1, '{1'b0, AXIS_NONE, 16'sd0, 10'd0}},
		'{'{OP_ENCODER, 2'd1, 6'd0,       10'd0},    1'b1, '{1'b0, AXIS_NONE, 16'sd0, 10'd0}},
		'{'{OP_ENCODER, 2'd2, 6'd0,       10'd0},    1'b1, '{1'b0, AXIS_NONE, 16'sd0, 10'd0}},
		'{'{OP_RATE,    2'd0, 6'd0,       10'h3FF},  1'b1, '{1'b0, AXIS_NONE, 16'sd0, 10'd1016}},
		'{'{OP_TICK,    2'd0, 6'd0,       10'd0},    1'b1, '{1'b0, AXIS_NONE, 16'sd0, 10'd1016}},
		'{'{OP_BUTTONS, 2'd0, 6'd0,       10'd0},    1'b1, '{1'b0, AXIS_NONE, 16'sd0, 10'd1016}},
		'{'{OP_BUTTONS, 2'd0, 6'b001001,  10'd0},    1'b1, '{1'b0, AXIS_X,    16'sd0, 10'd0}},
		'{'{OP_ENCODER, 2'd1, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd2, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_TICK,    2'd0, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_RATE,    2'd0, 6'd0,       10'h007},  1'b0, '0},
		'{'{OP_BUTTONS, 2'd0, 6'b010010,  10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd3, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd0, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_BUTTONS, 2'd0, 6'b100100,  10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd1, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd2, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd3, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd0, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_BUTTONS, 2'd0, 6'b111000,  10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd1, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd2, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_BUTTONS, 2'd0, 6'b000111,  10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd3, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_ENCODER, 2'd0, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_TICK,    2'd0, 6'd0,       10'd0},    1'b0, '0},
		'{'{OP_RATE,    2'd0, 6'd0,       10'h3FF},  1'b0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        operation = '0;
	logic [1:0]        encoder_bits = '0;
	logic [5:0]        buttons = '0;
	logic [9:0]        rate_sample = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              command_sent;
	logic [1:0]        axis;
	logic signed [15:0] position;
	logic [9:0]        rate;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;

	handwheel_jog_axis_controller u_top (
		.clk, .arst_n,
		.in_valid, .in_ready, .operation, .encoder_bits, .buttons, .rate_sample,
		.out_valid, .out_ready, .command_sent, .axis, .position, .rate,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// jog state mirror
	logic [3:0] phase_hist = '0;
	axis_t      sel_axis = AXIS_NONE;
	logic [6:0] step_size = '0;
	logic       change_pending = 1'b0;
	logic [7:0] tick_count = '0;
	pos_t       axis_pos [4] = '{default: '0};
	rate_t      axis_rate [4] = '{default: '0};
	pos_t       lim_lo [4] = '{16'sd0, X_LO_RST, Y_LO_RST, Z_LO_RST};
	pos_t       lim_hi [4] = '{16'sd0, X_HI_RST, Y_HI_RST, Z_HI_RST};
	logic [7:0] send_delay = DELAY_RST;

	result_t jog_results [$];
	int      mismatch_count = 0;
	int      src_idle = 0;
	int      sink_stall = 0;
	int      quiet_cycles = 0;

	function automatic void jog_move(input int delta);
		int v;
		v = int'(axis_pos[sel_axis]) + delta;
		if (v > int'(lim_hi[sel_axis])) v = int'(lim_hi[sel_axis]);
		if (v < int'(lim_lo[sel_axis])) v = int'(lim_lo[sel_axis]);
		axis_pos[sel_axis] = pos_t'(v);
	endfunction

	function automatic result_t jog_step(input jog_word_t w);
		result_t r;
		logic    sent;
		axis_t   prev;
		axis_t   shown;
		sent = 1'b0;
		prev = sel_axis;
		case (w.op)
			OP_ENCODER: begin
				phase_hist = {phase_hist[1:0], w.enc};
				if (phase_hist == HIST_UP) begin
					jog_move(int'(step_size));
					change_pending = 1'b1;
				end else if (phase_hist == HIST_DOWN) begin
					jog_move(-int'(step_size));
					change_pending = 1'b1;
				end
			end
			OP_BUTTONS: begin
				if (w.btn != '0) begin
					sent = change_pending && prev != AXIS_NONE;
					tick_count = '0;
					change_pending = 1'b0;
					sel_axis = w.btn[0] ? AXIS_X : w.btn[1] ? AXIS_Y :
						w.btn[2] ? AXIS_Z : AXIS_NONE;
					step_size = w.btn[3] ? STEP_1 : w.btn[4] ? STEP_10 :
						w.btn[5] ? STEP_100 : 7'd0;
				end
			end
			OP_RATE: axis_rate[sel_axis] = w.smp & RATE_MASK;
			default: begin
				if (tick_count != TICK_MAX) tick_count++;
				if (tick_count >= send_delay && change_pending && sel_axis != AXIS_NONE) begin
					sent = 1'b1;
					tick_count = '0;
					change_pending = 1'b0;
				end
			end
		endcase
		shown = (sent && w.op == OP_BUTTONS) ? prev : sel_axis;
		r.sent = sent;
		r.axis = shown;
		r.position = axis_pos[shown];
		r.rate = axis_rate[shown];
		return r;
	endfunction

	function automatic void limits_write(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_X_LO:  lim_lo[AXIS_X] = data;
			REG_X_HI:  lim_hi[AXIS_X] = data;
			REG_Y_LO:  lim_lo[AXIS_Y] = data;
			REG_Y_HI:  lim_hi[AXIS_Y] = data;
			REG_Z_LO:  lim_lo[AXIS_Z] = data;
			REG_Z_HI:  lim_hi[AXIS_Z] = data;
			REG_DELAY: send_delay = data[7:0];
			default: ;
		endcase
	endfunction

	// register value for a given phase; upper byte of the delay word is don't-care
	function automatic logic [15:0] phase_reg(input int p, input logic [2:0] idx);
		logic [15:0] lo_v;
		logic [15:0] hi_v;
		logic [7:0]  dly;
		case (p)
			1, 6: begin
				lo_v = -16'($urandom_range(400));
				hi_v = 16'($urandom_range(400));
				dly = 8'($urandom_range(3, 1));
			end
			2: begin
				lo_v = 16'h8000;
				hi_v = 16'h7FFF;
				dly = 8'hFF;
			end
			3: begin
				// crossed limits
				lo_v = 16'($urandom_range(300, 50));
				hi_v = -16'($urandom_range(50));
				dly = 8'h00;
			end
			4: begin
				if (idx == REG_X_LO || idx == REG_X_HI) lo_v = 16'h7FFF;
				else if (idx == REG_Y_LO || idx == REG_Y_HI) lo_v = 16'h8000;
				else lo_v = 16'h0000;
				hi_v = lo_v;
				dly = 8'd1;
			end
			5: begin
				lo_v = 16'($urandom);
				hi_v = 16'($urandom);
				dly = 8'($urandom);
			end
			7: begin
				lo_v = -16'($urandom_range(1500));
				hi_v = 16'($urandom_range(1500));
				dly = 8'($urandom_range(20));
			end
			default: begin
				lo_v = (idx == REG_X_LO) ? X_LO_RST : (idx == REG_Y_LO) ? Y_LO_RST : Z_LO_RST;
				hi_v = (idx == REG_X_HI) ? X_HI_RST : (idx == REG_Y_HI) ? Y_HI_RST : Z_HI_RST;
				dly = DELAY_RST;
			end
		endcase
		case (idx)
			REG_X_LO, REG_Y_LO, REG_Z_LO: return lo_v;
			REG_DELAY: return {8'($urandom), dly};
			default: return hi_v;
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		limits_write(idx, data);
	endtask

	task automatic send_word(input jog_word_t w, input logic typed, input result_t want);
		result_t r;
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= w.op;
		encoder_bits <= w.enc;
		buttons <= w.btn;
		rate_sample <= w.smp;
		do @(posedge clk); while (!in_ready);
		r = jog_step(w);
		jog_results.push_back(typed ? want : r);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (jog_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_words(input int n);
		jog_word_t w;
		int        k;
		int        pick;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(99);
			w.enc = 2'($urandom);
			w.btn = 6'($urandom);
			w.smp = 10'($urandom);
			if (pick < 40) begin
				// a full detent: 01->10 steps up, 11->00 steps down
				w.op = OP_ENCODER;
				w.enc = $urandom_range(1) ? 2'd1 : 2'd3;
				send_word(w, 1'b0, '0);
				w.enc = (w.enc == 2'd1) ? 2'd2 : 2'd0;
				send_word(w, 1'b0, '0);
				k += 2;
			end else begin
				if (pick < 50) w.op = OP_ENCODER;
				else if (pick < 75) w.op = OP_TICK;
				else if (pick < 88) begin
					w.op = OP_BUTTONS;
					if ($urandom_range(3) != 0) begin
						w.btn[2:0] = ($urandom_range(7) == 0) ? 3'd0 : 3'd1 << $urandom_range(2);
						w.btn[5:3] = ($urandom_range(7) == 0) ? 3'd0 : 3'd1 << $urandom_range(2);
					end
				end else w.op = OP_RATE;
				send_word(w, 1'b0, '0);
				k++;
			end
		end
	endtask

	// result check and watchdog
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (out_valid && out_ready) begin
			got = {command_sent, axis, position, rate};
			if (jog_results.size() == 0) begin
				$display("%0t: unexpected word sent=%0d axis=%0d pos=%0d rate=%0d",
					$time, got.sent, got.axis, got.position, got.rate);
				mismatch_count++;
			end else begin
				want = jog_results.pop_front();
				if (got.sent !== want.sent || got.axis !== want.axis ||
				    got.position !== want.position || got.rate !== want.rate) begin
					$display("%0t: expected sent=%0d axis=%0d pos=%0d rate=%0d, got sent=%0d axis=%0d pos=%0d rate=%0d",
						$time, want.sent, want.axis, want.position, want.rate,
						got.sent, got.axis, got.position, got.rate);
					mismatch_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= sink_stall);
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int p;
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out-of-range index is ignored; delay word with zero low byte means zero delay
		write_reg(REG_UNUSED, 16'h1234);
		write_reg(REG_DELAY, 16'hFF00);
		cfg_valid <= 1'b0;

		for (r = 0; r < 27; r++)
			send_word(DIRECTED[r].w, DIRECTED[r].typed, DIRECTED[r].want);
		drain();

		for (p = 0; p < PHASES; p++) begin
			write_reg(REG_X_LO, phase_reg(p, REG_X_LO));
			write_reg(REG_X_HI, phase_reg(p, REG_X_HI));
			write_reg(REG_Y_LO, phase_reg(p, REG_Y_LO));
			write_reg(REG_Y_HI, phase_reg(p, REG_Y_HI));
			write_reg(REG_Z_LO, phase_reg(p, REG_Z_LO));
			write_reg(REG_Z_HI, phase_reg(p, REG_Z_HI));
			write_reg(REG_DELAY, phase_reg(p, REG_DELAY));
			write_reg(REG_UNUSED, 16'($urandom));
			cfg_valid <= 1'b0;
			case (p % 4)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 71; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 71; end
				default: begin src_idle = 36; sink_stall = 36; end
			endcase
			random_words(WORDS_PER_PHASE);
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// ===== handwheel_jog_axis_controller.f =====
src/hjog_pkg.sv
src/hjog_cfg.sv
src/hjog_core.sv
src/handwheel_jog_axis_controller.sv
bench/tb_top.sv
